// File: src/jpsp_pkg.sv
// Package with the shared widths and direction codes of the jump point successor judge.
`timescale 1ns / 1ps

package jpsp_pkg;

   // Width of one grid coordinate.
   localparam int COORD_BITS = 12;

   // Signed width that holds a coordinate plus or minus a coordinate distance.
   localparam int WIDE_BITS = COORD_BITS + 2;

   // Largest coordinate value.
   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   // Number of configuration registers and the width of their index.
   localparam int CSR_COUNT = 2;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GOAL_X = 1'b0,
      CSR_GOAL_Y = 1'b1
   } csr_index_type;

   // Neighbor directions; north is toward smaller rows.
   typedef enum logic [2:0] {
      DIR_N  = 3'd0,
      DIR_NE = 3'd1,
      DIR_E  = 3'd2,
      DIR_SE = 3'd3,
      DIR_S  = 3'd4,
      DIR_SW = 3'd5,
      DIR_W  = 3'd6,
      DIR_NW = 3'd7
   } dir_type;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;

endpackage

// File: src/jump_point_successor_prune_clamp.sv
// Jump point successor judge: neighbor pruning, rejection of invalid destinations and goal-crossing clamp.
`timescale 1ns / 1ps

// A beat accepted at a rising edge is loaded into the input register and judged, and its result
// is loaded into the result register, which drives the rsp_ ports.
// Throughput: one beat per cycle; busy is always low since an input register and a result
// register bound one short stage of comparisons, subtractions and selects.
// Reset (synchronous, active high) clears both valid flags and sets goal_x and goal_y to 0.
// Results cannot be stalled: each one is on the ports, marked by rsp_valid, for exactly one cycle.
module jump_point_successor_prune_clamp (
   input  logic                               clock,
   input  logic                               reset,
   // Command channel.
   input  logic                               start,
   output logic                               busy,
   input  logic [jpsp_pkg::COORD_BITS-1:0]    req_cell_x,
   input  logic [jpsp_pkg::COORD_BITS-1:0]    req_cell_y,
   input  logic                               req_has_parent,
   input  logic [jpsp_pkg::COORD_BITS-1:0]    req_parent_x,
   input  logic [jpsp_pkg::COORD_BITS-1:0]    req_parent_y,
   input  logic [7:0]                         req_open_mask,
   input  logic [2:0]                         req_cand_dir,
   input  logic [jpsp_pkg::COORD_BITS-1:0]    req_dest_x,
   input  logic [jpsp_pkg::COORD_BITS-1:0]    req_dest_y,
   input  logic                               req_dest_valid,
   // Result channel.
   output logic                               rsp_valid,
   output logic                               rsp_accepted,
   output logic [jpsp_pkg::COORD_BITS-1:0]    rsp_succ_x,
   output logic [jpsp_pkg::COORD_BITS-1:0]    rsp_succ_y,
   // Configuration write port.
   input  logic                               csr_we,
   input  logic [jpsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [jpsp_pkg::COORD_BITS-1:0]    csr_wdata
);

   // The forced-neighbor rule: the diagonal counts when the orthogonal cell on the
   // parent side is blocked and the diagonal cell itself is open.
   function automatic logic [7:0] forced(input logic [7:0] open, input jpsp_pkg::dir_type side,
                                         input jpsp_pkg::dir_type diag);
      logic [7:0] bits;
      bits = '0;
      if (!open[side] && open[diag]) begin
         bits[diag] = 1'b1;
      end
      return bits;
   endfunction

   function automatic logic [7:0] dir_bit(input jpsp_pkg::dir_type d);
      logic [7:0] bits;
      bits = '0;
      bits[d] = 1'b1;
      return bits;
   endfunction

   // Directions that survive pruning, given the direction toward the parent.
   function automatic logic [7:0] allowed_set(input jpsp_pkg::dir_type pdir,
                                              input logic [7:0] open);
      logic [7:0] set;
      case (pdir)
         jpsp_pkg::DIR_N: begin
            set = dir_bit(jpsp_pkg::DIR_S)
                | forced(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_SE)
                | forced(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_SW);
         end
         jpsp_pkg::DIR_NE: begin
            set = dir_bit(jpsp_pkg::DIR_SW) | dir_bit(jpsp_pkg::DIR_S) | dir_bit(jpsp_pkg::DIR_W)
                | forced(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NW)
                | forced(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_SE);
         end
         jpsp_pkg::DIR_E: begin
            set = dir_bit(jpsp_pkg::DIR_W)
                | forced(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NW)
                | forced(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SW);
         end
         jpsp_pkg::DIR_SE: begin
            set = dir_bit(jpsp_pkg::DIR_NW) | dir_bit(jpsp_pkg::DIR_W) | dir_bit(jpsp_pkg::DIR_N)
                | forced(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SW)
                | forced(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_NE);
         end
         jpsp_pkg::DIR_S: begin
            set = dir_bit(jpsp_pkg::DIR_N)
                | forced(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_NE)
                | forced(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_NW);
         end
         jpsp_pkg::DIR_SW: begin
            set = dir_bit(jpsp_pkg::DIR_NE) | dir_bit(jpsp_pkg::DIR_N) | dir_bit(jpsp_pkg::DIR_E)
                | forced(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SE)
                | forced(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_NW);
         end
         jpsp_pkg::DIR_W: begin
            set = dir_bit(jpsp_pkg::DIR_E)
                | forced(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NE)
                | forced(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SE);
         end
         default: begin
            set = dir_bit(jpsp_pkg::DIR_SE) | dir_bit(jpsp_pkg::DIR_E) | dir_bit(jpsp_pkg::DIR_S)
                | forced(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NE)
                | forced(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_SW);
         end
      endcase
      return set;
   endfunction

   // Clamp a widened coordinate into the grid range.
   function automatic jpsp_pkg::coord_type sat(input jpsp_pkg::wide_type v);
      jpsp_pkg::coord_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({2'b00, jpsp_pkg::COORD_MAX})) begin
         r = jpsp_pkg::COORD_MAX;
      end else begin
         r = v[jpsp_pkg::COORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic jpsp_pkg::wide_type widen(input jpsp_pkg::coord_type c);
      return $signed({2'b00, c});
   endfunction

   // Goal registers.
   jpsp_pkg::coord_type goal_x_ff, goal_y_ff;

   // Input register.
   logic                valid_ff;
   jpsp_pkg::coord_type cell_x_ff, cell_y_ff, parent_x_ff, parent_y_ff, dest_x_ff, dest_y_ff;
   logic                has_parent_ff, dest_valid_ff;
   logic [7:0]          open_mask_ff;
   jpsp_pkg::dir_type   cand_dir_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_accepted_ff;
   jpsp_pkg::coord_type rsp_succ_x_ff, rsp_succ_y_ff;

   // Next values of the result register.
   logic                rsp_accepted_in;
   jpsp_pkg::coord_type rsp_succ_x_in, rsp_succ_y_in;

   logic                accept_beat;

   // Every cycle can take a new beat.
   assign busy        = 1'b0;
   assign accept_beat = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
      end else if (csr_we) begin
         case (jpsp_pkg::csr_index_type'(csr_index))
            jpsp_pkg::CSR_GOAL_X: goal_x_ff <= csr_wdata;
            jpsp_pkg::CSR_GOAL_Y: goal_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept_beat;
      end
      if (accept_beat) begin
         cell_x_ff      <= req_cell_x;
         cell_y_ff      <= req_cell_y;
         has_parent_ff  <= req_has_parent;
         parent_x_ff    <= req_parent_x;
         parent_y_ff    <= req_parent_y;
         open_mask_ff   <= req_open_mask;
         cand_dir_ff    <= jpsp_pkg::dir_type'(req_cand_dir);
         dest_x_ff      <= req_dest_x;
         dest_y_ff      <= req_dest_y;
         dest_valid_ff  <= req_dest_valid;
      end
   end

   // Judge and clamp the registered beat.
   always_comb begin
      jpsp_pkg::dir_type   pdir;
      logic [7:0]          set;
      logic                crossx, crossy;
      jpsp_pkg::coord_type dxg, dyg;
      jpsp_pkg::wide_type  ny_step, nx_step, nx_new, ny_new;

      // Direction toward the parent; a parent on the cell itself counts as west.
      if (parent_y_ff == cell_y_ff) begin
         pdir = (parent_x_ff > cell_x_ff) ? jpsp_pkg::DIR_E : jpsp_pkg::DIR_W;
      end else if (parent_y_ff < cell_y_ff) begin
         pdir = (parent_x_ff < cell_x_ff) ? jpsp_pkg::DIR_NW :
                (parent_x_ff > cell_x_ff) ? jpsp_pkg::DIR_NE : jpsp_pkg::DIR_N;
      end else begin
         pdir = (parent_x_ff < cell_x_ff) ? jpsp_pkg::DIR_SW :
                (parent_x_ff > cell_x_ff) ? jpsp_pkg::DIR_SE : jpsp_pkg::DIR_S;
      end
      set = has_parent_ff ? allowed_set(pdir, open_mask_ff) : 8'hFF;

      dxg = (goal_x_ff > cell_x_ff) ? goal_x_ff - cell_x_ff : cell_x_ff - goal_x_ff;
      dyg = (goal_y_ff > cell_y_ff) ? goal_y_ff - cell_y_ff : cell_y_ff - goal_y_ff;

      crossx = (cell_x_ff < goal_x_ff && goal_x_ff <= dest_x_ff)
            || (cell_x_ff > goal_x_ff && goal_x_ff >= dest_x_ff);
      crossy = (cell_y_ff < goal_y_ff && goal_y_ff <= dest_y_ff)
            || (cell_y_ff > goal_y_ff && goal_y_ff >= dest_y_ff);

      // Move along the edge's diagonal by the distance to the goal on the other axis.
      ny_step = (dest_y_ff > cell_y_ff) ? widen(cell_y_ff) + widen(dxg)
                                        : widen(cell_y_ff) - widen(dxg);
      nx_step = (dest_x_ff > cell_x_ff) ? widen(cell_x_ff) + widen(dyg)
                                        : widen(cell_x_ff) - widen(dyg);

      nx_new = widen(dest_x_ff);
      ny_new = widen(dest_y_ff);
      if (crossx && crossy) begin
         if (dxg < dyg) begin
            nx_new = widen(goal_x_ff);
            ny_new = ny_step;
         end else begin
            ny_new = widen(goal_y_ff);
            nx_new = nx_step;
         end
      end else if (crossx) begin
         nx_new = widen(goal_x_ff);
         if (cell_y_ff != dest_y_ff) begin
            ny_new = ny_step;
         end
      end else if (crossy) begin
         ny_new = widen(goal_y_ff);
         if (cell_x_ff != dest_x_ff) begin
            nx_new = nx_step;
         end
      end

      rsp_accepted_in = set[cand_dir_ff] & dest_valid_ff;
      // A rejected edge reports a zero successor.
      rsp_succ_x_in = rsp_accepted_in ? sat(nx_new) : '0;
      rsp_succ_y_in = rsp_accepted_in ? sat(ny_new) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_succ_x_ff   <= rsp_succ_x_in;
      rsp_succ_y_ff   <= rsp_succ_y_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_succ_x   = rsp_succ_x_ff;
   assign rsp_succ_y   = rsp_succ_y_ff;

endmodule

// File: tb/jump_point_successor_prune_clamp_test.sv
// Testbench for the jump point successor judge: directed and random edges checked by a scoreboard.
`timescale 1ns / 1ps

module jump_point_successor_prune_clamp_test;

   // One candidate edge as the sender presents it on the req_ ports.
   typedef struct packed {
      jpsp_pkg::coord_type cell_x;
      jpsp_pkg::coord_type cell_y;
      logic                has_parent;
      jpsp_pkg::coord_type parent_x;
      jpsp_pkg::coord_type parent_y;
      logic [7:0]          open_mask;
      jpsp_pkg::dir_type   cand_dir;
      jpsp_pkg::coord_type dest_x;
      jpsp_pkg::coord_type dest_y;
      logic                dest_valid;
   } edge_item_type;

   // One judged successor as it leaves on the rsp_ ports.
   typedef struct packed {
      logic                accepted;
      jpsp_pkg::coord_type succ_x;
      jpsp_pkg::coord_type succ_y;
   } succ_type;

   // The scoreboard keeps its own copy of the goal registers, predicts the successor of
   // every accepted edge and compares each result beat with the oldest prediction.
   class successor_scoreboard;
      succ_type            expected_q[$];
      jpsp_pkg::coord_type goal_x;
      jpsp_pkg::coord_type goal_y;
      int                  errors;

      function new();
         goal_x = '0;
         goal_y = '0;
         errors = 0;
      endfunction

      function void set_goal(jpsp_pkg::coord_type x, jpsp_pkg::coord_type y);
         goal_x = x;
         goal_y = y;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      static function jpsp_pkg::coord_type saturate(int v);
         if (v < 0) return '0;
         if (v > int'(jpsp_pkg::COORD_MAX)) return jpsp_pkg::COORD_MAX;
         return jpsp_pkg::coord_type'(v);
      endfunction

      static function logic [7:0] dir_bit(jpsp_pkg::dir_type d);
         return 8'd1 << d;
      endfunction

      // A diagonal is forced when the orthogonal cell on the parent side is blocked and
      // the diagonal cell itself is open.
      static function logic [7:0] forced_dir(logic [7:0] open, jpsp_pkg::dir_type side,
                                             jpsp_pkg::dir_type diag);
         return (!open[side] && open[diag]) ? dir_bit(diag) : 8'd0;
      endfunction

      // Direction from the cell toward its parent; a parent on the cell counts as west.
      static function jpsp_pkg::dir_type parent_heading(jpsp_pkg::coord_type cx,
                                                        jpsp_pkg::coord_type cy,
                                                        jpsp_pkg::coord_type px,
                                                        jpsp_pkg::coord_type py);
         if (py == cy) return (px > cx) ? jpsp_pkg::DIR_E : jpsp_pkg::DIR_W;
         if (py < cy)
            return (px < cx) ? jpsp_pkg::DIR_NW
                             : ((px > cx) ? jpsp_pkg::DIR_NE : jpsp_pkg::DIR_N);
         return (px < cx) ? jpsp_pkg::DIR_SW
                          : ((px > cx) ? jpsp_pkg::DIR_SE : jpsp_pkg::DIR_S);
      endfunction

      static function logic [7:0] pruned_dirs(jpsp_pkg::dir_type pdir, logic [7:0] open);
         case (pdir)
            jpsp_pkg::DIR_N:
               return dir_bit(jpsp_pkg::DIR_S)
                      | forced_dir(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_SE)
                      | forced_dir(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_SW);
            jpsp_pkg::DIR_NE:
               return dir_bit(jpsp_pkg::DIR_SW) | dir_bit(jpsp_pkg::DIR_S)
                      | dir_bit(jpsp_pkg::DIR_W)
                      | forced_dir(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NW)
                      | forced_dir(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_SE);
            jpsp_pkg::DIR_E:
               return dir_bit(jpsp_pkg::DIR_W)
                      | forced_dir(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NW)
                      | forced_dir(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SW);
            jpsp_pkg::DIR_SE:
               return dir_bit(jpsp_pkg::DIR_NW) | dir_bit(jpsp_pkg::DIR_W)
                      | dir_bit(jpsp_pkg::DIR_N)
                      | forced_dir(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SW)
                      | forced_dir(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_NE);
            jpsp_pkg::DIR_S:
               return dir_bit(jpsp_pkg::DIR_N)
                      | forced_dir(open, jpsp_pkg::DIR_E, jpsp_pkg::DIR_NE)
                      | forced_dir(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_NW);
            jpsp_pkg::DIR_SW:
               return dir_bit(jpsp_pkg::DIR_NE) | dir_bit(jpsp_pkg::DIR_N)
                      | dir_bit(jpsp_pkg::DIR_E)
                      | forced_dir(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SE)
                      | forced_dir(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_NW);
            jpsp_pkg::DIR_W:
               return dir_bit(jpsp_pkg::DIR_E)
                      | forced_dir(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NE)
                      | forced_dir(open, jpsp_pkg::DIR_S, jpsp_pkg::DIR_SE);
            default:
               return dir_bit(jpsp_pkg::DIR_SE) | dir_bit(jpsp_pkg::DIR_E)
                      | dir_bit(jpsp_pkg::DIR_S)
                      | forced_dir(open, jpsp_pkg::DIR_N, jpsp_pkg::DIR_NE)
                      | forced_dir(open, jpsp_pkg::DIR_W, jpsp_pkg::DIR_SW);
         endcase
      endfunction

      // Pruning, rejection of invalid destinations and the goal-crossing clamp.
      function succ_type judge_edge(edge_item_type e);
         logic [7:0] allowed;
         int         tx, ty, nx, ny, gx, gy, dxg, dyg;
         bit         crossx, crossy;
         succ_type   r;
         r = '0;
         allowed = e.has_parent
                   ? pruned_dirs(parent_heading(e.cell_x, e.cell_y, e.parent_x, e.parent_y),
                                 e.open_mask)
                   : 8'hFF;
         if (!(allowed[e.cand_dir] && e.dest_valid)) return r;
         tx = int'(e.cell_x);
         ty = int'(e.cell_y);
         nx = int'(e.dest_x);
         ny = int'(e.dest_y);
         gx = int'(goal_x);
         gy = int'(goal_y);
         dyg = (gy > ty) ? gy - ty : ty - gy;
         dxg = (gx > tx) ? gx - tx : tx - gx;
         crossx = (tx < gx && gx <= nx) || (tx > gx && gx >= nx);
         crossy = (ty < gy && gy <= ny) || (ty > gy && gy >= ny);
         if (crossx && crossy) begin
            if (dxg < dyg) begin
               nx = gx;
               ny = (ny > ty) ? ty + dxg : ty - dxg;
            end else begin
               ny = gy;
               nx = (nx > tx) ? tx + dyg : tx - dyg;
            end
         end else if (crossx) begin
            nx = gx;
            if (ty != ny) ny = (ny > ty) ? ty + dxg : ty - dxg;
         end else if (crossy) begin
            ny = gy;
            if (tx != nx) nx = (nx > tx) ? tx + dyg : tx - dyg;
         end
         r.accepted = 1'b1;
         r.succ_x = saturate(nx);
         r.succ_y = saturate(ny);
         return r;
      endfunction

      function void note_edge(edge_item_type e);
         expected_q.insert(expected_q.size(), judge_edge(e));
      endfunction

      task check_successor(succ_type got);
         succ_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing outstanding (accepted %0b x %0d y %0d)",
                             got.accepted, got.succ_x, got.succ_y));
         end else begin
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted)
               report($sformatf("accepted %0b, predicted %0b", got.accepted, want.accepted));
            if (got.succ_x !== want.succ_x)
               report($sformatf("succ_x %0d, predicted %0d", got.succ_x, want.succ_x));
            if (got.succ_y !== want.succ_y)
               report($sformatf("succ_y %0d, predicted %0d", got.succ_y, want.succ_y));
         end
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   jpsp_pkg::coord_type                 req_cell_x;
   jpsp_pkg::coord_type                 req_cell_y;
   logic                                req_has_parent;
   jpsp_pkg::coord_type                 req_parent_x;
   jpsp_pkg::coord_type                 req_parent_y;
   logic [7:0]                          req_open_mask;
   logic [2:0]                          req_cand_dir;
   jpsp_pkg::coord_type                 req_dest_x;
   jpsp_pkg::coord_type                 req_dest_y;
   logic                                req_dest_valid;
   logic                                rsp_valid;
   logic                                rsp_accepted;
   jpsp_pkg::coord_type                 rsp_succ_x;
   jpsp_pkg::coord_type                 rsp_succ_y;
   logic                                csr_we;
   logic [jpsp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   jpsp_pkg::coord_type                 csr_wdata;

   successor_scoreboard sb;

   // When clear, the sender presents a new edge on every cycle that busy allows.
   bit idle_enabled;

   jump_point_successor_prune_clamp dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_has_parent (req_has_parent),
      .req_parent_x   (req_parent_x),
      .req_parent_y   (req_parent_y),
      .req_open_mask  (req_open_mask),
      .req_cand_dir   (req_cand_dir),
      .req_dest_x     (req_dest_x),
      .req_dest_y     (req_dest_y),
      .req_dest_valid (req_dest_valid),
      .rsp_valid      (rsp_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_succ_x     (rsp_succ_x),
      .rsp_succ_y     (rsp_succ_y),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is cut off here if the block stops answering; the bound leaves a very wide
   // margin over the length of a correct run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Result beats cannot be held off, so every cycle with rsp_valid high is one beat.
   // Sampling at the rising edge sees the values that were on the ports during the
   // cycle that the edge ends.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_successor('{accepted: rsp_accepted, succ_x: rsp_succ_x, succ_y: rsp_succ_y});
   end

   // Unit offset of one step in a direction; north is toward smaller rows.
   function automatic void dir_step(jpsp_pkg::dir_type d, output int sx, output int sy);
      case (d)
         jpsp_pkg::DIR_N:  begin sx =  0; sy = -1; end
         jpsp_pkg::DIR_NE: begin sx =  1; sy = -1; end
         jpsp_pkg::DIR_E:  begin sx =  1; sy =  0; end
         jpsp_pkg::DIR_SE: begin sx =  1; sy =  1; end
         jpsp_pkg::DIR_S:  begin sx =  0; sy =  1; end
         jpsp_pkg::DIR_SW: begin sx = -1; sy =  1; end
         jpsp_pkg::DIR_W:  begin sx = -1; sy =  0; end
         default:          begin sx = -1; sy = -1; end
      endcase
   endfunction

   function automatic edge_item_type edge_of(int cx, int cy, bit hp, int px, int py,
                                             logic [7:0] mask, jpsp_pkg::dir_type d,
                                             int dx, int dy, bit dv);
      edge_item_type e;
      e.cell_x     = jpsp_pkg::coord_type'(cx);
      e.cell_y     = jpsp_pkg::coord_type'(cy);
      e.has_parent = hp;
      e.parent_x   = jpsp_pkg::coord_type'(px);
      e.parent_y   = jpsp_pkg::coord_type'(py);
      e.open_mask  = mask;
      e.cand_dir   = d;
      e.dest_x     = jpsp_pkg::coord_type'(dx);
      e.dest_y     = jpsp_pkg::coord_type'(dy);
      e.dest_valid = dv;
      return e;
   endfunction

   // Most random edges are well formed: the cell lies near the goal, the destination lies
   // on the line of the candidate direction and the parent on one of the eight lines, so
   // that pruning, forced neighbors and every kind of goal crossing are reached often.
   // The rest place cells, parents and destinations anywhere in the grid.
   function automatic edge_item_type random_edge(jpsp_pkg::coord_type gx,
                                                 jpsp_pkg::coord_type gy);
      edge_item_type     e;
      int                sx, sy, k, pick;
      jpsp_pkg::dir_type pd;
      pick = $urandom_range(99);
      if (pick < 6) begin
         e.cell_x = $urandom_range(1) ? jpsp_pkg::COORD_MAX : '0;
         e.cell_y = $urandom_range(1) ? jpsp_pkg::COORD_MAX : '0;
      end else if (pick < 30) begin
         e.cell_x = jpsp_pkg::coord_type'($urandom);
         e.cell_y = jpsp_pkg::coord_type'($urandom);
      end else begin
         e.cell_x = successor_scoreboard::saturate(int'(gx) + int'($urandom_range(64)) - 32);
         e.cell_y = successor_scoreboard::saturate(int'(gy) + int'($urandom_range(64)) - 32);
      end
      e.cand_dir = jpsp_pkg::dir_type'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 80) begin
         dir_step(e.cand_dir, sx, sy);
         k = $urandom_range(48, 1);
         e.dest_x = successor_scoreboard::saturate(int'(e.cell_x) + k * sx);
         e.dest_y = successor_scoreboard::saturate(int'(e.cell_y) + k * sy);
      end else if (pick < 85) begin
         e.dest_x = e.cell_x;
         e.dest_y = e.cell_y;
      end else begin
         e.dest_x = jpsp_pkg::coord_type'($urandom);
         e.dest_y = jpsp_pkg::coord_type'($urandom);
      end
      e.dest_valid = ($urandom_range(99) < 88);
      e.has_parent = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 75) begin
         pd = jpsp_pkg::dir_type'($urandom_range(7));
         dir_step(pd, sx, sy);
         k = $urandom_range(30, 1);
         e.parent_x = successor_scoreboard::saturate(int'(e.cell_x) + k * sx);
         e.parent_y = successor_scoreboard::saturate(int'(e.cell_y) + k * sy);
      end else if (pick < 85) begin
         e.parent_x = e.cell_x;
         e.parent_y = e.cell_y;
      end else begin
         e.parent_x = jpsp_pkg::coord_type'($urandom);
         e.parent_y = jpsp_pkg::coord_type'($urandom);
      end
      e.open_mask = 8'($urandom);
      return e;
   endfunction

   // Presents one edge and holds it until a rising edge with busy low takes it. With
   // idling on, the sender first lets a random number of empty cycles pass.
   task automatic issue_edge(edge_item_type e);
      if (idle_enabled) begin
         while ($urandom_range(99) < 34) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start          <= 1'b1;
      req_cell_x     <= e.cell_x;
      req_cell_y     <= e.cell_y;
      req_has_parent <= e.has_parent;
      req_parent_x   <= e.parent_x;
      req_parent_y   <= e.parent_y;
      req_open_mask  <= e.open_mask;
      req_cand_dir   <= e.cand_dir;
      req_dest_x     <= e.dest_x;
      req_dest_y     <= e.dest_y;
      req_dest_valid <= e.dest_valid;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_edge(e);
   endtask

   // Lowers start and waits, with a bound, until every predicted beat has come back,
   // then lets the input and result registers settle so the block is idle for register writes.
   task automatic finish_phase();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (sb.pending() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes goal_x and then goal_y on back-to-back edges; the block is idle here.
   task automatic set_goal(jpsp_pkg::coord_type x, jpsp_pkg::coord_type y);
      csr_we    <= 1'b1;
      csr_index <= jpsp_pkg::CSR_GOAL_X;
      csr_wdata <= x;
      @(posedge clock);
      csr_index <= jpsp_pkg::CSR_GOAL_Y;
      csr_wdata <= y;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_goal(x, y);
   endtask

   initial begin
      jpsp_pkg::coord_type gx, gy;
      sb = new();
      idle_enabled = 1'b1;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_cell_x     <= '0;
      req_cell_y     <= '0;
      req_has_parent <= 1'b0;
      req_parent_x   <= '0;
      req_parent_y   <= '0;
      req_open_mask  <= '0;
      req_cand_dir   <= jpsp_pkg::DIR_N;
      req_dest_x     <= '0;
      req_dest_y     <= '0;
      req_dest_valid <= 1'b0;
      csr_we         <= 1'b0;
      csr_index      <= jpsp_pkg::CSR_GOAL_X;
      csr_wdata      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edges around a goal at column 20, row 100.
      set_goal(12'd20, 12'd100);
      // Without a parent every direction passes; an invalid destination is rejected with zeros.
      issue_edge(edge_of(0, 0, 0, 0, 0, 8'h00, jpsp_pkg::DIR_N, 0, 0, 1));
      issue_edge(edge_of(4095, 4095, 0, 0, 0, 8'hFF, jpsp_pkg::DIR_SW, 4000, 4095, 0));
      // A parent on the cell itself behaves as a parent to the west.
      issue_edge(edge_of(50, 50, 1, 50, 50, 8'hFF, jpsp_pkg::DIR_E, 60, 50, 1));
      issue_edge(edge_of(50, 50, 1, 50, 50, 8'hFF, jpsp_pkg::DIR_W, 40, 50, 1));
      // Parent to the north: the natural move, a forced diagonal and a pruned one.
      issue_edge(edge_of(50, 50, 1, 50, 40, 8'hFF, jpsp_pkg::DIR_S, 50, 60, 1));
      issue_edge(edge_of(50, 50, 1, 50, 40, 8'h08, jpsp_pkg::DIR_SE, 60, 60, 1));
      issue_edge(edge_of(50, 50, 1, 50, 40, 8'hFF, jpsp_pkg::DIR_SE, 60, 60, 1));
      // One edge per remaining parent direction, natural or forced.
      issue_edge(edge_of(50, 50, 1, 60, 40, 8'h00, jpsp_pkg::DIR_SW, 40, 60, 1));
      issue_edge(edge_of(50, 50, 1, 60, 50, 8'h80, jpsp_pkg::DIR_NW, 40, 40, 1));
      issue_edge(edge_of(50, 50, 1, 60, 60, 8'h02, jpsp_pkg::DIR_NE, 60, 40, 1));
      issue_edge(edge_of(50, 50, 1, 50, 60, 8'h80, jpsp_pkg::DIR_NW, 40, 40, 1));
      issue_edge(edge_of(50, 50, 1, 40, 60, 8'h08, jpsp_pkg::DIR_SE, 60, 60, 1));
      issue_edge(edge_of(50, 50, 1, 40, 50, 8'h02, jpsp_pkg::DIR_NE, 60, 40, 1));
      issue_edge(edge_of(50, 50, 1, 40, 40, 8'h20, jpsp_pkg::DIR_SW, 40, 60, 1));
      // Crossing the goal column only, the goal row only, and both on a diagonal.
      issue_edge(edge_of(10, 50, 0, 0, 0, 8'hFF, jpsp_pkg::DIR_E, 40, 50, 1));
      issue_edge(edge_of(20, 90, 0, 0, 0, 8'hFF, jpsp_pkg::DIR_S, 20, 120, 1));
      issue_edge(edge_of(10, 80, 0, 0, 0, 8'hFF, jpsp_pkg::DIR_SE, 40, 110, 1));
      issue_edge(edge_of(0, 95, 0, 0, 0, 8'hFF, jpsp_pkg::DIR_SE, 30, 125, 1));
      // An off-line destination whose clamp would go below row zero saturates.
      issue_edge(edge_of(10, 5, 0, 0, 0, 8'hFF, jpsp_pkg::DIR_NE, 30, 0, 1));
      // Opposite corners as cell and parent.
      issue_edge(edge_of(4095, 0, 1, 0, 4095, 8'hFF, jpsp_pkg::DIR_NE, 4095, 0, 1));
      finish_phase();

      // An off-line destination whose clamp would run past the last row saturates high.
      set_goal(12'd4090, 12'd100);
      issue_edge(edge_of(4080, 4094, 0, 0, 0, 8'hFF, jpsp_pkg::DIR_SE, 4095, 4095, 1));
      issue_edge(edge_of(4095, 4095, 1, 4095, 4095, 8'hFF, jpsp_pkg::DIR_E, 4095, 4095, 1));
      finish_phase();

      // Random phases over the corner goals, one random goal and a goal on the center column at a random row.
      // The third phase runs without idling so back-to-back beats are covered.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin gx = '0;                  gy = '0;                  end
            1: begin gx = jpsp_pkg::COORD_MAX; gy = jpsp_pkg::COORD_MAX; end
            2: begin gx = jpsp_pkg::COORD_MAX; gy = '0;                  end
            3: begin gx = '0;                  gy = jpsp_pkg::COORD_MAX; end
            4: begin
               gx = jpsp_pkg::coord_type'($urandom);
               gy = jpsp_pkg::coord_type'($urandom);
            end
            default: begin gx = 12'd2048; gy = jpsp_pkg::coord_type'($urandom); end
         endcase
         set_goal(gx, gy);
         idle_enabled = (p != 2);
         repeat (155) issue_edge(random_edge(gx, gy));
         finish_phase();
      end

      if (sb.pending() != 0)
         sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
src/jpsp_pkg.sv
src/jump_point_successor_prune_clamp.sv
tb/jump_point_successor_prune_clamp_test.sv
